FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the neighbor run filter. Each macro names the
// clock and the reset so that the check is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CNRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cnrf_pkg.sv
// ----------------------------------------------------------------------------
// cnrf_pkg
// Types, codes and the run-length table shared by the neighbor run filter.
// ----------------------------------------------------------------------------
package cnrf_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RUN     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd2;

  // Register field widths and reset values.
  localparam int CFG_DATA_BITS = 16;
  localparam int RUN_BITS      = 5;
  localparam int GW_BITS       = 11;
  localparam int GH_BITS       = 16;
  localparam int ROW_BITS      = GH_BITS + 1;

  localparam logic [RUN_BITS-1:0] MIN_RUN_RESET     = 5'd1;
  localparam logic [GW_BITS-1:0]  GRID_WIDTH_RESET  = 11'd1024;
  localparam logic [GH_BITS-1:0]  GRID_HEIGHT_RESET = 16'd1024;

  // Input word kinds.
  localparam logic ACT_CELL = 1'b0;
  localparam logic ACT_PAD  = 1'b1;

  // Position flags of the center cell that a word completes.
  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } pos_flags_t;

  // Longest circular run of ones over two laps of eight neighbor bits.
  typedef logic [255:0][RUN_BITS-1:0] run_tab_t;

  function automatic run_tab_t build_run_table();
    run_tab_t   tab;
    int         run;
    int         best;
    logic [7:0] bits;
    for (int i = 0; i < 256; i++) begin
      bits = 8'(i);
      run  = 0;
      best = 0;
      for (int lap = 0; lap < 2; lap++) begin
        for (int d = 0; d < 8; d++) begin
          if (bits[d]) begin
            run = run + 1;
          end else begin
            if (run > best) best = run;
            run = 0;
          end
        end
      end
      if (run > best) best = run;
      tab[i] = RUN_BITS'(best);
    end
    return tab;
  endfunction

  localparam run_tab_t RUN_TABLE = build_run_table();

endpackage

FILE: sv/cnrf_line_store.sv
// ----------------------------------------------------------------------------
// cnrf_line_store
// Two-row line store: one word per column holds the previous row and the row
// before it. One write and one registered read per cycle, with write-to-read
// bypass when both touch the same column in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnrf_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a same-cycle write to the same column wins.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  // A column written one cycle and read the next returns the written word.
  `CNRF_ASSERT_NEXT(a_wr_then_rd, clk, rst, $past(wr_en) && rd_en && rd_addr == $past(wr_addr) && !(wr_en && wr_addr == rd_addr), rd_data == $past(wr_data, 2), "line store lost a write")

endmodule

FILE: sv/cnrf_eval.sv
// ----------------------------------------------------------------------------
// cnrf_eval
// 3x3 window of nonzero bits, run-length test of the center cell, and the
// output register of the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnrf_eval #(
  parameter int VALUE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             shift,
  input  logic [2:0]                       col_nz,
  input  logic [VALUE_BITS:0]              col_mid,
  input  cnrf_pkg::pos_flags_t             col_flags,
  input  logic [cnrf_pkg::RUN_BITS-1:0]    min_run,
  output logic                             s2_free,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [VALUE_BITS-1:0]     area_value,
  output logic                             marked,
  output logic                             last_of_frame
);

  localparam int EW = VALUE_BITS + 1;

  // Window columns: bit 0 top row, bit 1 middle row, bit 2 bottom row.
  logic [2:0]    left_nz;
  logic [2:0]    mid_nz;
  logic [2:0]    right_nz;
  logic [EW-1:0] right_ctr;
  logic [EW-1:0] center;

  logic                 s2_valid;
  cnrf_pkg::pos_flags_t s2_flags;

  logic                          out_free;
  logic [7:0]                    nb_bits;
  logic [cnrf_pkg::RUN_BITS-1:0] run_len;
  logic [VALUE_BITS-1:0]         cval;
  logic                          keep;

  assign out_free = !out_valid || !out_stall;
  assign s2_free  = !s2_valid || !s2_flags.emit || out_free;

  // Window shift as each word leaves the line store stage.
  always_ff @(posedge clk) begin
    if (shift) begin
      left_nz   <= mid_nz;
      mid_nz    <= right_nz;
      right_nz  <= col_nz;
      center    <= right_ctr;
      right_ctr <= col_mid;
      s2_flags  <= col_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (shift) begin
      s2_valid <= 1'b1;
    end else if (s2_free) begin
      s2_valid <= 1'b0;
    end
  end

  // Neighbors in cyclic order N, NE, E, SE, S, SW, W, NW, masked at the edges.
  always_comb begin
    nb_bits[0] = mid_nz[0]   & s2_flags.top_ok;
    nb_bits[1] = right_nz[0] & s2_flags.top_ok & s2_flags.right_ok;
    nb_bits[2] = right_nz[1] & s2_flags.right_ok;
    nb_bits[3] = right_nz[2] & s2_flags.bottom_ok & s2_flags.right_ok;
    nb_bits[4] = mid_nz[2]   & s2_flags.bottom_ok;
    nb_bits[5] = left_nz[2]  & s2_flags.bottom_ok & s2_flags.left_ok;
    nb_bits[6] = left_nz[1]  & s2_flags.left_ok;
    nb_bits[7] = left_nz[0]  & s2_flags.top_ok & s2_flags.left_ok;
  end

  // Keep test on the center cell.
  assign run_len = cnrf_pkg::RUN_TABLE[nb_bits];
  assign cval    = center[VALUE_BITS-1:0];
  assign keep    = (cval != '0) && center[VALUE_BITS] && (run_len >= min_run);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid && s2_flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid && s2_flags.emit) begin
      area_value    <= keep ? cval : '0;
      marked        <= keep;
      last_of_frame <= s2_flags.last;
    end
  end

  // A marked word always carries its nonzero value, an unmarked one zero.
  `CNRF_ASSERT_NOW(a_marked_nonzero, clk, rst, out_valid && marked, area_value != '0, "marked word with zero value")
  `CNRF_ASSERT_NOW(a_unmarked_zero, clk, rst, out_valid && !marked, area_value == '0, "unmarked word with nonzero value")

endmodule

FILE: sv/circular_neighbor_run_filter.sv
// ----------------------------------------------------------------------------
// circular_neighbor_run_filter
// Streaming 3x3 filter that keeps a raster cell when its longest circular run
// of nonzero neighbors reaches min_run.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   action, cell_value, cell_has_data
//   out      from block out_valid/out_stall area_value, marked, last_of_frame
//   config   to block   write_enable        write_index, write_data
//
// One input word per cycle is sustained unless the output stalls, as the line
// store takes one read and one write each cycle (one column word per word).
// A cell's result is due once the word grid_width+1 places later is accepted;
// it then moves through stage 1 and the window stage to the output register.
// Reset is synchronous; no clearing pass, the edge masks hide stale rows.
// A stall on the output holds the output register; input is still taken
// until the two internal stages behind it are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_neighbor_run_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  write_enable,
  input  logic [cnrf_pkg::CFG_INDEX_BITS-1:0]   write_index,
  input  logic [cnrf_pkg::CFG_DATA_BITS-1:0]    write_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic signed [VALUE_BITS-1:0]          cell_value,
  input  logic                                  cell_has_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [VALUE_BITS-1:0]          area_value,
  output logic                                  marked,
  output logic                                  last_of_frame
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WBITS    = $clog2(MAX_WIDTH + 1);
  localparam int EW       = VALUE_BITS + 1;
  localparam int RB       = cnrf_pkg::ROW_BITS;

  // Configuration registers.
  logic [cnrf_pkg::RUN_BITS-1:0] min_run;
  logic [cnrf_pkg::GW_BITS-1:0]  grid_width;
  logic [cnrf_pkg::GH_BITS-1:0]  grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run     <= cnrf_pkg::MIN_RUN_RESET;
      grid_width  <= cnrf_pkg::GRID_WIDTH_RESET;
      grid_height <= cnrf_pkg::GRID_HEIGHT_RESET;
    end else if (write_enable) begin
      case (write_index)
        cnrf_pkg::REG_MIN_RUN:     min_run     <= write_data[cnrf_pkg::RUN_BITS-1:0];
        cnrf_pkg::REG_GRID_WIDTH:  grid_width  <= write_data[cnrf_pkg::GW_BITS-1:0];
        cnrf_pkg::REG_GRID_HEIGHT: grid_height <= write_data[cnrf_pkg::GH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, width clamps to the line store.
  logic [WBITS-1:0] w_eff;
  logic [RB-1:0]    h_ext;
  logic [RB-1:0]    h_plus1;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = WBITS'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = WBITS'(MAX_WIDTH);
    end else begin
      w_eff = WBITS'(grid_width);
    end
  end

  assign h_ext   = (grid_height == '0) ? RB'(1) : RB'(grid_height);
  assign h_plus1 = h_ext + RB'(1);

  // Handshake through the two internal stages.
  logic s1_valid;
  logic s2_free;
  logic s1_free;
  logic in_accept;
  logic shift;

  assign s1_free   = !s1_valid || s2_free;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;
  assign shift     = s1_valid && s2_free;

  // Input position counters.
  logic [COL_BITS-1:0] column_count;
  logic [RB-1:0]       row_count;
  logic [WBITS-1:0]    col_inc;
  logic                col_nz;

  assign col_inc = WBITS'(column_count) + WBITS'(1);
  assign col_nz  = (column_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (row_count >= h_plus1) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (col_inc >= w_eff) begin
        column_count <= '0;
        row_count    <= row_count + RB'(1);
      end else begin
        column_count <= col_inc[COL_BITS-1:0];
      end
    end
  end

  // Entry for the store and edge flags of the center cell this word completes.
  logic [EW-1:0]        entry_in;
  cnrf_pkg::pos_flags_t flags_in;

  always_comb begin
    if ((row_count < h_ext) && (action == cnrf_pkg::ACT_CELL)) begin
      entry_in = {cell_has_data, cell_value};
    end else begin
      entry_in = '0;
    end
    if (col_nz) begin
      flags_in.emit      = (row_count >= RB'(1)) && (row_count <= h_ext);
      flags_in.top_ok    = (row_count >= RB'(2));
      flags_in.bottom_ok = (row_count < h_ext);
      flags_in.left_ok   = (column_count >= COL_BITS'(2));
      flags_in.right_ok  = 1'b1;
      flags_in.last      = 1'b0;
    end else begin
      flags_in.emit      = (row_count >= RB'(2)) && (row_count <= h_plus1);
      flags_in.top_ok    = (row_count >= RB'(3));
      flags_in.bottom_ok = (row_count <= h_ext);
      flags_in.left_ok   = (w_eff >= WBITS'(2));
      flags_in.right_ok  = 1'b0;
      flags_in.last      = (row_count == h_plus1);
    end
  end

  // Stage 1: word waits for its column word from the line store.
  logic [COL_BITS-1:0]  s1_col;
  logic [EW-1:0]        s1_entry;
  cnrf_pkg::pos_flags_t s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col   <= column_count;
      s1_entry <= entry_in;
      s1_flags <= flags_in;
    end
  end

  // Line store: upper half the previous row, lower half the row before it.
  logic [2*EW-1:0] rd_data;
  logic [2*EW-1:0] wr_data;
  logic [EW-1:0]   row1_entry;
  logic [EW-1:0]   row2_entry;

  assign row1_entry = rd_data[2*EW-1:EW];
  assign row2_entry = rd_data[EW-1:0];
  assign wr_data    = {s1_entry, row1_entry};

  cnrf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_BITS),
    .DW    (2 * EW)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (column_count),
    .rd_data (rd_data),
    .wr_en   (shift),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // Nonzero bits of the new window column, top to bottom in bits 0 to 2.
  logic [2:0] col_bits;

  assign col_bits = {s1_entry[VALUE_BITS-1:0] != '0,
                     row1_entry[VALUE_BITS-1:0] != '0,
                     row2_entry[VALUE_BITS-1:0] != '0};

  cnrf_eval #(
    .VALUE_BITS (VALUE_BITS)
  ) u_eval (
    .clk           (clk),
    .rst           (rst),
    .shift         (shift),
    .col_nz        (col_bits),
    .col_mid       (row1_entry),
    .col_flags     (s1_flags),
    .min_run       (min_run),
    .s2_free       (s2_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .area_value    (area_value),
    .marked        (marked),
    .last_of_frame (last_of_frame)
  );

  // The pad word after the last row returns the counters to the frame start.
  `CNRF_ASSERT_NEXT(a_frame_wrap, clk, rst, in_accept && row_count >= h_plus1, row_count == '0 && column_count == '0, "frame did not wrap")
  // Inside the frame the position always moves off the frame start.
  `CNRF_ASSERT_NEXT(a_frame_step, clk, rst, in_accept && row_count < h_ext, row_count != '0 || column_count != '0, "position wrapped early")

endmodule
